// ===== hw/rtl/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and helper functions of the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // Character codes used by the decoder.
    localparam logic [7:0] C_CHAR_PAD   = 8'h3D;
    localparam logic [7:0] C_CHAR_UP_A  = 8'h41;
    localparam logic [7:0] C_CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] C_CHAR_LO_A  = 8'h61;
    localparam logic [7:0] C_CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] C_CHAR_DIG_0 = 8'h30;
    localparam logic [7:0] C_CHAR_DIG_9 = 8'h39;
    localparam logic [7:0] C_CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] C_CHAR_SLASH = 8'h2F;

    // Sextet offsets of the lower case and digit ranges.
    localparam logic [5:0] C_OFS_LOWER = 6'd26;
    localparam logic [5:0] C_OFS_DIGIT = 6'd52;
    localparam logic [5:0] C_SEXT_PLUS  = 6'd62;
    localparam logic [5:0] C_SEXT_SLASH = 6'd63;

    // Number of sextets in a complete group, minus one.
    localparam logic [1:0] C_LAST_SLOT = 2'd3;

    // One queue entry: up to three result beats that one character releases.
    typedef struct packed {
        logic [2:0][7:0] bytes;    // byte for beat k at bytes[k]
        logic [1:0]      num_m1;   // number of beats minus one
        logic            valid;    // 0 for a bare end marker
        logic            last;     // the final beat closes the string
    } t_grp;

    // Maps a character to its sextet. Bit 6 is set when the code is not
    // part of the alphabet.
    function automatic logic [6:0] f_map_char(input logic [7:0] c);
        logic [7:0] diff;
        logic [6:0] res;
        diff = 8'd0;
        res  = 7'h40;
        if (c >= C_CHAR_UP_A && c <= C_CHAR_UP_Z) begin
            diff = c - C_CHAR_UP_A;
            res  = {1'b0, diff[5:0]};
        end else if (c >= C_CHAR_LO_A && c <= C_CHAR_LO_Z) begin
            diff = c - C_CHAR_LO_A;
            res  = {1'b0, diff[5:0] + C_OFS_LOWER};
        end else if (c >= C_CHAR_DIG_0 && c <= C_CHAR_DIG_9) begin
            diff = c - C_CHAR_DIG_0;
            res  = {1'b0, diff[5:0] + C_OFS_DIGIT};
        end else if (c == C_CHAR_PLUS) begin
            res = {1'b0, C_SEXT_PLUS};
        end else if (c == C_CHAR_SLASH) begin
            res = {1'b0, C_SEXT_SLASH};
        end
        return res;
    endfunction

    // Packs four sextets into three bytes.
    function automatic logic [2:0][7:0] f_group(
        input logic [5:0] s0,
        input logic [5:0] s1,
        input logic [5:0] s2,
        input logic [5:0] s3
    );
        logic [2:0][7:0] b;
        b[0] = {s0, s1[5:4]};
        b[1] = {s1[3:0], s2[5:2]};
        b[2] = {s2[1:0], s3};
        return b;
    endfunction

endpackage

// ===== hw/rtl/b64d_front.sv =====
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, collects sextets and turns each finished group or
// string end into one queue entry.
// ----------------------------------------------------------------------------
module b64d_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // [7:0] char_code
    input  logic          s_axis_tlast,   // end_of_string
    input  logic          i_full,
    output logic          o_push,
    output b64d_pkg::t_grp o_grp
);
    import b64d_pkg::*;

    logic [2:0][5:0] r_st;
    logic [2:0][5:0] n_st;
    logic [1:0]      r_cnt;
    logic [1:0]      n_cnt;
    logic            r_pad;
    logic            w_accept;
    logic [6:0]      w_map;
    logic            w_keep;
    logic            w_full_grp;
    logic [5:0]      w_tail_s2;
    logic [2:0][7:0] w_full_bytes;
    logic [2:0][7:0] w_tail_bytes;

    assign s_axis_tready = !i_full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Classify the character.
    assign w_map      = f_map_char(s_axis_tdata);
    assign w_keep     = !r_pad && (s_axis_tdata != C_CHAR_PAD) && !w_map[6];
    assign w_full_grp = w_keep && (r_cnt == C_LAST_SLOT);

    // Sextet store and count after this character.
    always_comb begin
        n_st  = r_st;
        n_cnt = r_cnt;
        if (w_keep) begin
            case (r_cnt)
                2'd0: begin
                    n_st[0] = w_map[5:0];
                end
                2'd1: begin
                    n_st[1] = w_map[5:0];
                end
                2'd2: begin
                    n_st[2] = w_map[5:0];
                end
                default: begin
                    n_st = r_st;
                end
            endcase
            n_cnt = r_cnt + 2'd1;
        end
    end

    // Bytes of a complete group and of a partial group at string end.
    assign w_full_bytes = f_group(r_st[0], r_st[1], r_st[2], w_map[5:0]);
    assign w_tail_s2    = (n_cnt == C_LAST_SLOT) ? n_st[2] : 6'd0;
    assign w_tail_bytes = f_group(n_st[0], n_st[1], w_tail_s2, 6'd0);

    // Build the queue entry.
    always_comb begin
        o_grp = '0;
        if (w_full_grp) begin
            o_grp.bytes  = w_full_bytes;
            o_grp.num_m1 = 2'd2;
            o_grp.valid  = 1'b1;
            o_grp.last   = s_axis_tlast;
        end else if (n_cnt >= 2'd2) begin
            o_grp.bytes  = w_tail_bytes;
            o_grp.num_m1 = n_cnt - 2'd2;
            o_grp.valid  = 1'b1;
            o_grp.last   = 1'b1;
        end else begin
            o_grp.last   = 1'b1;
        end
    end

    assign o_push = w_accept && (w_full_grp || s_axis_tlast);

    // Group state; a string end returns everything to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= '0;
            r_cnt <= '0;
            r_pad <= 1'b0;
        end else if (w_accept) begin
            if (s_axis_tlast) begin
                r_st  <= '0;
                r_cnt <= '0;
                r_pad <= 1'b0;
            end else begin
                r_st  <= n_st;
                r_cnt <= n_cnt;
                r_pad <= r_pad || (s_axis_tdata == C_CHAR_PAD);
            end
        end
    end

endmodule

// ===== hw/rtl/b64d_queue.sv =====
// ----------------------------------------------------------------------------
// b64d_queue
// Small first-in first-out queue of group entries between front and back.
// ----------------------------------------------------------------------------
module b64d_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64d_pkg::t_grp i_wr_grp,
    input  logic           i_pop,
    output b64d_pkg::t_grp o_rd_grp,
    output logic           o_full,
    output logic           o_empty
);
    import b64d_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_grp          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_wr;
    logic          w_rd;

    assign o_full   = (r_count == FULL_CNT);
    assign o_empty  = (r_count == '0);
    assign w_wr     = i_push && !o_full;
    assign w_rd     = i_pop && !o_empty;
    assign o_rd_grp = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_grp;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/b64d_back.sv =====
// ----------------------------------------------------------------------------
// b64d_back
// Takes group entries from the queue and sends their bytes one beat at a
// time through a registered output stage.
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  b64d_pkg::t_grp i_grp,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [7:0]     m_axis_tdata,   // [7:0] data_byte
    output logic           m_axis_tuser,   // byte_valid
    output logic           m_axis_tlast    // last_of_string
);
    import b64d_pkg::*;

    t_grp       r_ent;
    logic       r_have;
    logic [1:0] r_idx;
    logic       r_ovalid;
    logic [7:0] r_odata;
    logic       r_ouser;
    logic       r_olast;
    logic       w_out_free;
    logic       w_emit;
    logic       w_last_one;
    logic [7:0] w_byte;

    assign w_out_free = !r_ovalid || m_axis_tready;
    assign w_emit     = r_have && w_out_free;
    assign w_last_one = (r_idx == r_ent.num_m1);
    assign o_pop      = !i_empty && (!r_have || (w_emit && w_last_one));

    // Byte of the current beat.
    always_comb begin
        case (r_idx)
            2'd0: begin
                w_byte = r_ent.bytes[0];
            end
            2'd1: begin
                w_byte = r_ent.bytes[1];
            end
            2'd2: begin
                w_byte = r_ent.bytes[2];
            end
            default: begin
                w_byte = 8'd0;
            end
        endcase
    end

    // Working entry control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have   <= 1'b0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_have <= 1'b1;
                r_idx  <= '0;
            end else if (w_emit && w_last_one) begin
                r_have <= 1'b0;
            end else if (w_emit) begin
                r_idx <= r_idx + 2'd1;
            end
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Entry and output payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_grp;
        end
        if (w_emit) begin
            r_odata <= w_byte;
            r_ouser <= r_ent.valid;
            r_olast <= r_ent.last && w_last_one;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

endmodule

// ===== hw/rtl/base64_stream_decoder_core.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder_core
// Streaming base64 decoder: characters in, decoded bytes out.
// ----------------------------------------------------------------------------
// The block takes one character per beat and accepts a new one every cycle
// while its entry queue has room. Every fourth alphabet character releases
// three bytes; characters outside the alphabet are skipped, and the first '='
// ends decoding until the string's last character (tlast). On the last
// character a partial group of two or three sextets releases one or two
// bytes, and if nothing is left a single beat with tuser low marks the end.
// The output side sends one byte per cycle from a registered stage unless
// the output stalls, so the sustained rate is one character per cycle; a
// burst of string ends that outpaces the byte output is absorbed by the
// QUEUE_DEPTH-entry queue, and input ready drops only when it is full. A
// character's bytes pass the queue, entry register and output register.
// ----------------------------------------------------------------------------
module base64_stream_decoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_code
    input  logic       s_axis_tlast,   // end_of_string
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] data_byte
    output logic       m_axis_tuser,   // byte_valid
    output logic       m_axis_tlast    // last_of_string
);
    import b64d_pkg::*;

    t_grp w_wr_grp;
    t_grp w_rd_grp;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    // Front: classification and sextet collection.
    b64d_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_grp         (w_wr_grp)
    );

    // Entry queue between the two sides.
    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_wr_grp (w_wr_grp),
        .i_pop    (w_pop),
        .o_rd_grp (w_rd_grp),
        .o_full   (w_full),
        .o_empty  (w_empty)
    );

    // Back: byte serializer and output register.
    b64d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_grp         (w_rd_grp),
        .i_empty       (w_empty),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // No entry is pushed into a full queue.
    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("entry pushed into a full queue");

    // No entry is taken from an empty queue.
    a_no_underflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("entry popped from an empty queue");

    // A beat without a byte is always a bare end marker.
    a_marker_form : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == 8'd0)))
        else $error("malformed end marker beat");

endmodule

// ===== tb/base64_stream_decoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder_core_tb
// Self-checking bench for the streaming base64 decoder core.
// ----------------------------------------------------------------------------
// Characters go in as bursts of beats with random gaps. A scoreboard class
// decodes every accepted character on its own and queues the byte beats it
// expects. Each output beat is compared against the oldest queued beat while
// the output side stalls on a pattern that switches among four modes.
// A short directed run covers full groups, both padding forms, leftover
// sextets, skipped characters and bare end markers. Random strings follow:
// mostly well-formed text with noise, trailing junk and broken tails.
// ----------------------------------------------------------------------------
module base64_stream_decoder_core_tb;

    import b64d_pkg::*;

    localparam int  CYCLE_LIMIT  = 200000;
    localparam int  RANDOM_CHARS = 150;
    localparam int  DRAIN_CYCLES = 16;
    localparam string ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // One output beat as the decoder should produce it.
    typedef struct {
        logic [7:0] data;
        logic       has_byte;
        logic       last;
    } byte_beat_t;

    // Tracks the decoder state and the byte beats still owed by the block.
    class decoded_byte_board;
        logic [5:0] held [3];
        int         held_cnt;
        bit         pad_seen;
        byte_beat_t owed [$];
        int         errors;

        function new();
            held     = '{default: '0};
            held_cnt = 0;
            pad_seen = 0;
            errors   = 0;
        endfunction

        // Returns the sextet of a character, or bit 6 set if it is skipped.
        function logic [6:0] sextet_of(logic [7:0] c);
            if (c >= C_CHAR_UP_A && c <= C_CHAR_UP_Z) return {1'b0, 6'(c - C_CHAR_UP_A)};
            if (c >= C_CHAR_LO_A && c <= C_CHAR_LO_Z) return {1'b0, 6'(c - C_CHAR_LO_A + 26)};
            if (c >= C_CHAR_DIG_0 && c <= C_CHAR_DIG_9) return {1'b0, 6'(c - C_CHAR_DIG_0 + 52)};
            if (c == C_CHAR_PLUS) return 7'd62;
            if (c == C_CHAR_SLASH) return 7'd63;
            return 7'h40;
        endfunction

        function int outstanding();
            return owed.size();
        endfunction

        // Updates the state for an accepted character and queues its beats.
        function void note_char(logic [7:0] c, logic eos);
            logic [6:0] s;
            logic [7:0] out_bytes [$];
            logic [5:0] s2;
            byte_beat_t beat;
            if (!pad_seen) begin
                if (c == C_CHAR_PAD) begin
                    pad_seen = 1;
                end else begin
                    s = sextet_of(c);
                    if (!s[6]) begin
                        if (held_cnt < 3) begin
                            held[held_cnt] = s[5:0];
                            held_cnt++;
                        end else begin
                            out_bytes.push_back({held[0], held[1][5:4]});
                            out_bytes.push_back({held[1][3:0], held[2][5:2]});
                            out_bytes.push_back({held[2][1:0], s[5:0]});
                            held_cnt = 0;
                        end
                    end
                end
            end
            // At the string end a partial group flushes one or two bytes.
            if (eos) begin
                if (held_cnt >= 2) begin
                    s2 = (held_cnt == 3) ? held[2] : 6'd0;
                    out_bytes.push_back({held[0], held[1][5:4]});
                    if (held_cnt == 3) out_bytes.push_back({held[1][3:0], s2[5:2]});
                end
                held     = '{default: '0};
                held_cnt = 0;
                pad_seen = 0;
            end
            if (eos && out_bytes.size() == 0) begin
                beat = '{data: 8'h00, has_byte: 1'b0, last: 1'b1};
                owed.push_back(beat);
            end
            foreach (out_bytes[k]) begin
                beat = '{data: out_bytes[k], has_byte: 1'b1,
                         last: eos && (k == out_bytes.size() - 1)};
                owed.push_back(beat);
            end
        endfunction

        // Compares one output beat against the oldest owed beat.
        function void check_byte(logic [7:0] data, logic has_byte, logic last);
            byte_beat_t want;
            if (owed.size() == 0) begin
                $error("unexpected beat: data_byte=%0h byte_valid=%0b last_of_string=%0b",
                       data, has_byte, last);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (data !== want.data) begin
                $error("data_byte: expected %0h, got %0h", want.data, data);
                errors++;
            end
            if (has_byte !== want.has_byte) begin
                $error("byte_valid: expected %0b, got %0b", want.has_byte, has_byte);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_of_string: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] char_code
    logic       s_axis_tlast  = 1'b0;   // end_of_string
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] data_byte
    logic       m_axis_tuser;           // byte_valid
    logic       m_axis_tlast;           // last_of_string

    decoded_byte_board board = new();
    int cycles     = 0;
    int burst_left = 0;
    int chars_sent = 0;

    base64_stream_decoder_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock with a period of 10.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Output side: the stall pattern steps through four modes in turn, and
    // every accepted beat goes to the scoreboard.
    always @(posedge i_clk) begin
        case ((cycles / 48) % 4)
            0: begin
                m_axis_tready <= 1'b1;
            end
            1: begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_axis_tready <= (cycles % 4 == 0);
            end
            default: begin
                m_axis_tready <= ((cycles / 7) % 2 == 0);
            end
        endcase
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_byte(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // Sends one character beat; a new burst starts after a random gap.
    task automatic send_char(input logic [7:0] c, input logic eos);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eos;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_char(c, eos);
        burst_left--;
        chars_sent++;
    endtask

    // Sends a text, marking its last character as the string end if asked.
    task automatic send_text(input string txt, input bit closes);
        for (int k = 0; k < txt.len(); k++)
            send_char(txt[k], closes && (k == txt.len() - 1));
    endtask

    // Appends a character, sometimes preceded by a random noise byte.
    task automatic add_symbol(ref logic [7:0] txt [$], input logic [7:0] c);
        if ($urandom_range(0, 7) == 0) txt.push_back(8'($urandom_range(0, 255)));
        txt.push_back(c);
    endtask

    // Builds and sends one random string, mostly well formed.
    task automatic send_random_string();
        logic [7:0] txt [$];
        int groups;
        int tail;
        groups = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
        repeat (4 * groups) add_symbol(txt, ALPHABET[$urandom_range(0, 63)]);
        tail = $urandom_range(0, 5);
        case (tail)
            1: begin
                add_symbol(txt, ALPHABET[$urandom_range(0, 63)]);
            end
            2, 4: begin
                repeat (2) add_symbol(txt, ALPHABET[$urandom_range(0, 63)]);
            end
            3, 5: begin
                repeat (3) add_symbol(txt, ALPHABET[$urandom_range(0, 63)]);
            end
            default: begin
            end
        endcase
        if (tail == 2) begin
            txt.push_back(C_CHAR_PAD);
            txt.push_back(C_CHAR_PAD);
        end else if (tail == 3) begin
            txt.push_back(C_CHAR_PAD);
        end
        // Junk after the padding must be ignored until the string end.
        if ((tail == 2 || tail == 3) && $urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 1)) txt.push_back(ALPHABET[$urandom_range(0, 63)]);
                else txt.push_back(8'($urandom_range(0, 255)));
            end
        end
        if (txt.size() == 0) txt.push_back(8'($urandom_range(0, 255)));
        foreach (txt[k]) send_char(txt[k], k == txt.size() - 1);
    endtask

    initial begin
        int directed;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Full group, single and double padding, extremes of the alphabet.
        send_text("TWFu", 1);
        send_text("TWE=", 1);
        send_text("TQ==", 1);
        send_text("+/Az", 0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h80, 1'b0);
        send_text("a9Z0", 1);
        // Lone sextet, lone padding and a skipped character at the end.
        send_text("T", 1);
        send_char(C_CHAR_PAD, 1'b1);
        send_char(8'h2A, 1'b1);
        // Characters after the padding are ignored.
        send_text("Q=Wx", 1);
        directed = chars_sent;

        while (chars_sent < directed + RANDOM_CHARS) send_random_string();
        s_axis_tvalid <= 1'b0;

        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.outstanding() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
